// File: rtl/core/rbe_pkg.sv
// ----------------------------------------------------------------------------
// rbe_pkg
// Shared types and fixed constants of the byte-wise rANS encoder.
// ----------------------------------------------------------------------------
package rbe_pkg;

  // Fixed widths of the coder state and of the stream fields
  localparam int STATE_W     = 31;
  localparam int FIELD_W     = 16;
  localparam int BYTE_W      = 8;
  localparam int FLUSH_BYTES = 4;
  localparam int MAX_RENORM  = 4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture input beat and coder state
    logic emit_shift;  // emit low working byte, shift right by one byte
    logic div_init;    // seed the divider from the renormalized value
    logic div_step;    // one restoring division step
    logic finish;      // write the new coder state
    logic flush_emit;  // emit one flush byte, high byte first
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_flush;    // input beat asks for a flush
    logic in_zero;     // input beat has zero frequency
    logic can_shift;   // renormalization needs another byte
    logic out_free;    // output register can take a byte this cycle
    logic byte3;       // byte counter sits on the fourth byte
    logic div_done;    // divider is on its final step
  } status_t;

endpackage

// File: rtl/core/rbe_ctrl.sv
// ----------------------------------------------------------------------------
// rbe_ctrl
// Controller of the rANS encoder: sequences renormalize, divide and flush.
// ----------------------------------------------------------------------------
module rbe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  rbe_pkg::status_t st,
  output rbe_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RENORM = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_FIN    = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == S_IDLE);

  // Decode next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (st.in_flush) begin
            state_next = S_FLUSH;
          end else if (!st.in_zero) begin
            state_next = S_RENORM;
          end
        end
      end
      S_RENORM: begin
        if (st.can_shift) begin
          cmd.emit_shift = st.out_free;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      S_FLUSH: begin
        if (st.out_free) begin
          cmd.flush_emit = 1'b1;
          if (st.byte3) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/rbe_datapath.sv
// ----------------------------------------------------------------------------
// rbe_datapath
// Datapath of the rANS encoder: coder state, renormalize shifter,
// restoring divider and the output byte register.
// ----------------------------------------------------------------------------
module rbe_datapath #(
  parameter int PROB_BITS        = 16,
  parameter int LOWER_BOUND_BITS = 23
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      s_tdata,
  input  logic             s_tuser,
  input  rbe_pkg::cmd_t    cmd,
  output rbe_pkg::status_t st,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast
);

  localparam int SW = rbe_pkg::STATE_W;
  localparam int PB = PROB_BITS;
  localparam int QW = LOWER_BOUND_BITS - PROB_BITS + 8;  // quotient bits
  localparam int CW = $clog2(QW + 1);
  localparam int NW = SW + 1;
  localparam logic [SW-1:0] STATE_INIT = SW'(1) << LOWER_BOUND_BITS;

  logic [SW-1:0] coder_state;
  logic [SW-1:0] x;
  logic [PB-1:0] freq;
  logic [PB-1:0] start;
  logic [PB-1:0] rem;
  logic [QW-1:0] quo;
  logic [CW-1:0] cnt;

  logic [PB-1:0] in_start;
  logic [PB-1:0] in_freq;
  logic [SW-1:0] xmax;
  logic          ge;
  logic          ge_next;
  logic [PB:0]   trial;
  logic [PB:0]   trial_diff;
  logic          trial_ge;
  logic [NW-1:0] nx;
  logic [NW-1:0] xflush;
  logic [1:0]    flush_idx;

  // Take start and frequency modulo the probability total
  assign in_start = s_tdata[PB-1:0];
  assign in_freq  = s_tdata[rbe_pkg::FIELD_W +: PB];

  // Renormalize bound and compares on the working value
  assign xmax    = SW'(freq) << QW;
  assign ge      = (x >= xmax);
  assign ge_next = ((x >> rbe_pkg::BYTE_W) >= xmax);

  // One restoring division step
  assign trial      = {rem, quo[QW-1]};
  assign trial_ge   = (trial >= {1'b0, freq});
  assign trial_diff = trial - {1'b0, freq};

  // New state from quotient, remainder and start, wrapped to the state width
  assign nx = (NW'(quo) << PB) + NW'(rem) + NW'(start);

  // Flush byte selection, high byte first
  assign xflush    = {1'b0, x};
  assign flush_idx = 2'(rbe_pkg::FLUSH_BYTES - 1) - cnt[1:0];

  assign st.in_flush  = s_tuser;
  assign st.in_zero   = (in_freq == '0);
  assign st.can_shift = ge && (cnt != CW'(rbe_pkg::MAX_RENORM));
  assign st.out_free  = !m_tvalid || m_tready;
  assign st.byte3     = (cnt == CW'(rbe_pkg::FLUSH_BYTES - 1));
  assign st.div_done  = (cnt == CW'(QW - 1));

  // Hold the coder state
  always_ff @(posedge clk) begin
    if (rst) begin
      coder_state <= STATE_INIT;
    end else if (cmd.finish) begin
      coder_state <= nx[SW-1:0];
    end else if (cmd.flush_emit && st.byte3) begin
      coder_state <= STATE_INIT;
    end
  end

  // Working value, divider registers and step counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x     <= coder_state;
      freq  <= in_freq;
      start <= in_start;
      cnt   <= '0;
    end else if (cmd.emit_shift) begin
      x   <= x >> rbe_pkg::BYTE_W;
      cnt <= cnt + CW'(1);
    end else if (cmd.div_init) begin
      rem <= x[QW +: PB];
      quo <= x[QW-1:0];
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= trial_ge ? trial_diff[PB-1:0] : trial[PB-1:0];
      quo <= {quo[QW-2:0], trial_ge};
      cnt <= cnt + CW'(1);
    end else if (cmd.flush_emit) begin
      cnt <= cnt + CW'(1);
    end
  end

  // Output register: load a byte beat or drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_shift || cmd.flush_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_shift) begin
      m_tdata <= x[7:0];
      m_tlast <= st.byte3 || !ge_next;
    end else if (cmd.flush_emit) begin
      m_tdata <= xflush[flush_idx * rbe_pkg::BYTE_W +: rbe_pkg::BYTE_W];
      m_tlast <= st.byte3;
    end
  end

  // A byte is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_shift || cmd.flush_emit) |-> st.out_free)
    else $error("byte loaded over a pending output beat");

  // Renormalized value fits the divider
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    cmd.div_init |-> ((NW'(x) >> (PB + QW)) == '0))
    else $error("renormalized value exceeds divider range");

  // Remainder stays below the frequency through the division
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step || cmd.finish) |-> (rem < freq))
    else $error("division remainder out of range");

  // Flush restarts the coder state
  a_flush_restart: assert property (@(posedge clk) disable iff (rst)
    (cmd.flush_emit && st.byte3) |=> (coder_state == STATE_INIT))
    else $error("coder state not restarted after flush");

endmodule

// File: rtl/core/rans_byte_encoder_top.sv
// ----------------------------------------------------------------------------
// rans_byte_encoder_top
// Byte-wise rANS encoder with a 31-bit coder state, stream interfaces.
// ----------------------------------------------------------------------------
// Each input beat either encodes one symbol (tuser = 0, tdata carries start
// and frequency) or flushes (tuser = 1). An encode beat emits zero to two
// renormalization bytes, low byte first, with tlast on the final one, each
// byte waiting on tready when the output register is full, then runs a
// restoring divider one quotient bit per cycle. A zero-frequency beat is
// dropped and the encoder stays idle. A flush emits the four state bytes,
// high byte first, and restarts the state at 2^LOWER_BOUND_BITS. One beat
// is worked on at a time; the byte output register lets the last byte wait
// while the next beat is taken. The stored stream is the emitted order
// reversed, so symbols must be fed in reverse coding order.
// ----------------------------------------------------------------------------
module rans_byte_encoder_top #(
  parameter int PROB_BITS        = 16,
  parameter int LOWER_BOUND_BITS = 23
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] sym_start, [31:16] sym_freq
  input  logic        s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast
);

  rbe_pkg::cmd_t    cmd;
  rbe_pkg::status_t st;

  rbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  rbe_datapath #(
    .PROB_BITS        (PROB_BITS),
    .LOWER_BOUND_BITS (LOWER_BOUND_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .st       (st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: test/tb_rans_byte_encoder_top.sv
// ----------------------------------------------------------------------------
// tb_rans_byte_encoder_top
// Self-checking bench for the byte-wise rANS encoder.
// ----------------------------------------------------------------------------
// A queue of symbol and flush beats is built up front: a directed opening
// part, then random streams of well-formed symbols closed by a flush, mixed
// with zero-frequency and out-of-range beats. The driver feeds the queue
// into the slave port with random gaps. Each accepted beat runs through a
// bit-exact coder model that queues the bytes it should emit. The monitor
// stalls the master port at random and checks every byte and its tlast
// against the oldest queued byte.
// ----------------------------------------------------------------------------
module tb_rans_byte_encoder_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  P_BITS      = 16;
  localparam int  LB_BITS     = 23;
  localparam int  RAND_ITEMS  = 200;
  localparam int  TAIL_CYCLES = 40;
  localparam int  CYCLE_LIMIT = 200000;
  localparam int  MAX_REPORTS = 10;
  localparam bit  ACT_ENCODE  = 1'b0;
  localparam bit  ACT_FLUSH   = 1'b1;

  typedef struct packed {
    bit                        action;
    bit [rbe_pkg::FIELD_W-1:0] start;
    bit [rbe_pkg::FIELD_W-1:0] freq;
  } sym_beat_t;

  typedef struct packed {
    bit [rbe_pkg::BYTE_W-1:0] data;
    bit                       last;
  } out_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [15:0] sym_start, [31:16] sym_freq
  logic        s_tuser = 1'b0; // [0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [7:0] out_byte
  logic        m_tlast;

  // both queues take new entries at the front and hand out the oldest at the back
  sym_beat_t pending[$];
  out_beat_t exp_bytes[$];
  bit [rbe_pkg::STATE_W-1:0] coder_x;

  int total_items;
  int items_done;
  int bytes_checked;
  int flushes_done;
  int errors;
  int cycles;

  // driver and monitor state
  int        src_gap;
  bit        src_idle;
  sym_beat_t src_cur;
  int        sink_stall;
  bit        sink_idle;
  bit        sink_nxt;
  out_beat_t got;
  out_beat_t want;

  rans_byte_encoder_top #(
    .PROB_BITS        (P_BITS),
    .LOWER_BOUND_BITS (LB_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the coder model by one beat and queue the bytes it emits
  task automatic encode_beat(input sym_beat_t it);
    longint unsigned x;
    longint unsigned xmax;
    longint unsigned q;
    longint unsigned r;
    longint unsigned nx;
    out_beat_t ob;
    int n;
    if (it.action == ACT_FLUSH) begin
      for (int i = 0; i < rbe_pkg::FLUSH_BYTES; i++) begin
        ob.data = rbe_pkg::BYTE_W'(coder_x >> (24 - 8 * i));
        ob.last = (i == rbe_pkg::FLUSH_BYTES - 1);
        exp_bytes.push_front(ob);
      end
      coder_x = rbe_pkg::STATE_W'(1 << LB_BITS);
      flushes_done++;
      return;
    end
    if (it.freq == 0) return;
    x    = longint'(coder_x);
    xmax = longint'((1 << (LB_BITS - P_BITS)) << 8) * longint'(it.freq);
    n    = 0;
    // renormalize, low byte first; tlast marks the final shift
    while (x >= xmax && n < rbe_pkg::MAX_RENORM) begin
      ob.data = x[rbe_pkg::BYTE_W-1:0];
      x = x >> 8;
      n++;
      ob.last = !(x >= xmax && n < rbe_pkg::MAX_RENORM);
      exp_bytes.push_front(ob);
    end
    q  = x / longint'(it.freq);
    r  = x % longint'(it.freq);
    nx = (q << P_BITS) + r + longint'(it.start);
    coder_x = nx[rbe_pkg::STATE_W-1:0];
  endtask

  task automatic add_beat(input bit action, input int start, input int freq);
    sym_beat_t it;
    it.action = action;
    it.start  = rbe_pkg::FIELD_W'(start);
    it.freq   = rbe_pkg::FIELD_W'(freq);
    pending.push_front(it);
  endtask

  task automatic report(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endtask

  // Drive slave beats from the pending queue, one gap drawn per beat
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap  = 0;
      src_idle = 1'b1;
    end else begin
      if (s_tvalid && s_tready) begin
        encode_beat(src_cur);
        items_done++;
        if ($urandom_range(0, 31) == 0) src_idle = !src_idle;
        src_gap = src_idle ? $urandom_range(0, 3) : 0;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          src_cur = pending.pop_back();
          s_tdata <= {src_cur.freq, src_cur.start};
          s_tuser <= src_cur.action;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check master beats and stall tready at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      sink_stall = 0;
      sink_idle  = 1'b1;
    end else begin
      if (m_tvalid && m_tready) begin
        got.data = m_tdata;
        got.last = m_tlast;
        if (exp_bytes.size() == 0) begin
          report($sformatf("unexpected byte %02h last %0b", got.data, got.last));
        end else begin
          want = exp_bytes.pop_back();
          bytes_checked++;
          if (got.data !== want.data || got.last !== want.last)
            report($sformatf("byte %0d: expected %02h last %0b, got %02h last %0b",
                             bytes_checked, want.data, want.last, got.data, got.last));
        end
        if ($urandom_range(0, 31) == 0) sink_idle = !sink_idle;
        sink_stall = sink_idle ? $urandom_range(0, 3) : 0;
      end
      if (sink_stall > 0) begin
        sink_stall--;
        sink_nxt = 1'b0;
      end else begin
        sink_nxt = 1'b1;
      end
      m_tready <= sink_nxt;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d beats taken",
               cycles, items_done, total_items);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int target;
    int len;
    int f;
    int pick;
    coder_x = rbe_pkg::STATE_W'(1 << LB_BITS);

    // directed: field extremes, renorm depth, zero frequency, wrap, flushes
    add_beat(ACT_ENCODE, 0, 65535);       // no renormalization from reset
    add_beat(ACT_ENCODE, 0, 1);           // deepest renormalization
    add_beat(ACT_ENCODE, 65535, 1);       // start plus freq at the total
    add_beat(ACT_ENCODE, 12345, 0);       // dropped
    add_beat(ACT_ENCODE, 65535, 0);       // dropped, start all ones
    add_beat(ACT_ENCODE, 65535, 65535);   // sum above the total
    add_beat(ACT_ENCODE, 32768, 32768);
    add_beat(ACT_ENCODE, 0, 256);
    add_beat(ACT_ENCODE, 100, 257);
    add_beat(ACT_FLUSH, 0, 0);
    add_beat(ACT_FLUSH, 65535, 65535);    // back-to-back flush of the reset state
    add_beat(ACT_ENCODE, 1, 1);
    add_beat(ACT_ENCODE, 2, 1);
    add_beat(ACT_ENCODE, 3, 1);
    add_beat(ACT_ENCODE, 0, 2);
    add_beat(ACT_ENCODE, 40000, 25536);
    add_beat(ACT_FLUSH, 21845, 43690);
    add_beat(ACT_ENCODE, 0, 0);
    add_beat(ACT_FLUSH, 0, 0);

    // random streams closed by a flush, with some noise beats
    target = pending.size() + RAND_ITEMS;
    while (pending.size() < target) begin
      if ($urandom_range(0, 9) == 0) begin
        pick = $urandom_range(0, 2);
        if (pick == 0)
          add_beat(ACT_ENCODE, $urandom_range(0, 65535), 0);
        else if (pick == 1)
          add_beat(ACT_ENCODE, $urandom_range(0, 65535), $urandom_range(1, 65535));
        else
          add_beat(ACT_FLUSH, $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(0, 3);
          if (pick == 0)      f = $urandom_range(1, 255);
          else if (pick == 1) f = $urandom_range(256, 4095);
          else if (pick == 2) f = $urandom_range(4096, 65535);
          else                f = $urandom_range(1, 65535);
          add_beat(ACT_ENCODE, $urandom_range(0, 65536 - f), f);
        end
        add_beat(ACT_FLUSH, $urandom_range(0, 65535), $urandom_range(0, 65535));
      end
    end
    total_items = pending.size();

    // hold reset, then release
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // wait for every beat to be taken and every byte to come back
    @(negedge clk);
    while (items_done < total_items || exp_bytes.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (exp_bytes.size() != 0)
      report($sformatf("%0d expected bytes never arrived", exp_bytes.size()));

    $display("Coded %0d beats (%0d flushes) and checked %0d output bytes in %0d cycles.",
             items_done, flushes_done, bytes_checked, cycles);
    $display("Mismatches: %0d", errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
